### sv/ccm_pkg.sv
`default_nettype none

package ccm_pkg;

  // opcodes carried in the input tuser
  localparam logic [1:0] OP_HIT   = 2'd0;
  localparam logic [1:0] OP_EOE   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // plane codes
  localparam logic [1:0] PLANE_A = 2'd0;
  localparam logic [1:0] PLANE_B = 2'd1;
  localparam logic [1:0] PLANE_C = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_THR_A = 2'd0;
  localparam logic [1:0] REG_THR_B = 2'd1;
  localparam logic [1:0] REG_THR_C = 2'd2;

  localparam int          ThrWidth  = 16;
  localparam logic [15:0] THR_A_RST = 16'd100;
  localparam logic [15:0] THR_B_RST = 16'd40;
  localparam logic [15:0] THR_C_RST = 16'd40;

  // ratio in thousandths of a percent
  localparam int          RatioWidth  = 17;
  localparam logic [16:0] RATIO_SCALE = 17'd100000;

  localparam int OutCountWidth = 32;
  localparam int InDataWidth   = 48;
  localparam int OutDataWidth  = 88;

endpackage

`default_nettype wire

### sv/ccm_ratio.sv
`default_nettype none

// serial floor(1e5*num/den) clamped to 1e5 (0 if den=0), one add-compare per cycle
module ccm_ratio #(
  parameter int W = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [W-1:0]                    num_i,
  input  wire logic [W-1:0]                    den_i,
  output logic                                 done_o,
  output logic [ccm_pkg::RatioWidth-1:0]       ratio_o
);

  localparam int RW = ccm_pkg::RatioWidth;

  logic          busy_q, phase_q, done_q;
  logic [4:0]    bit_q;
  logic [W-1:0]  rem_q, r_q, den_q;
  logic [RW-1:0] quo_q, res_q;

  logic [W:0]    sum;
  logic          ge;
  logic [W-1:0]  rem_nx;
  logic [RW-1:0] quo_nx;

  // shared adder: doubling step or add-numerator step
  assign sum    = {1'b0, rem_q} + {1'b0, (phase_q ? r_q : rem_q)};
  assign ge     = (sum >= {1'b0, den_q});
  assign rem_nx = ge ? W'(sum - {1'b0, den_q}) : sum[W-1:0];
  assign quo_nx = phase_q ? (quo_q + RW'(ge)) : {quo_q[RW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        phase_q <= 1'b0;
        bit_q   <= 5'd16;
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else if (num_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (!phase_q && ccm_pkg::RATIO_SCALE[bit_q]) begin
          phase_q <= 1'b1;
        end else if (bit_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q   <= bit_q - 5'd1;
          phase_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      r_q   <= num_i;
      rem_q <= '0;
      quo_q <= '0;
      if (den_i == '0) begin
        res_q <= '0;
      end else begin
        res_q <= ccm_pkg::RATIO_SCALE;
      end
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
      res_q <= (quo_nx > ccm_pkg::RATIO_SCALE) ? ccm_pkg::RATIO_SCALE : quo_nx;
    end
  end

  assign done_o  = done_q;
  assign ratio_o = res_q;

endmodule

`default_nettype wire

### sv/coincidence_matrix_counter_core.sv
`default_nettype none

// Three-plane coincidence scaler. Hits (tuser opcode hit) set bits in per-event masks of
// planes A, B and C when energy is strictly above the plane's threshold and the segment is
// in range; a hit leaves the sequencer idle. An end-of-event item, when plane A has a hit,
// bumps the any-A counter and each hit A segment's counter, then walks the segment counters
// a,b,c one position a cycle and spends an extra write state on the triple store for every
// hit triple; the single port of the triple store sets the walk's length. A query with
// in-range indexes reads one triple cell and runs the serial ratio unit. After reset the
// triple store is swept to zero, one cell a cycle, over all NA*NB*NC cells (10560 by
// default) before the first item is taken. Counters saturate; outputs carry their low 32
// bits. Results wait in an output register, so hits keep flowing while a query result is
// not yet taken.
module coincidence_matrix_counter_core #(
  parameter int NUM_A_SEGMENTS = 15,
  parameter int NUM_B_SEGMENTS = 22,
  parameter int NUM_C_SEGMENTS = 32,
  parameter int COUNT_WIDTH    = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // cfg
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_idx_i,
  input  wire logic [ccm_pkg::ThrWidth-1:0]        cfg_data_i,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // plane[1:0], segment_id[8:2], energy_kev[24:9], query_a[30:25], query_b[36:31],
  // query_c[42:37], denom_any[43], zero fill
  input  wire logic [ccm_pkg::InDataWidth-1:0]     s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                          s_axis_tuser,
  // output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // numerator[31:0], denominator[63:32], ratio_milli_percent[80:64], index_error[81],
  // zero fill
  output logic [ccm_pkg::OutDataWidth-1:0]         m_axis_tdata
);

  localparam int NA    = NUM_A_SEGMENTS;
  localparam int NB    = NUM_B_SEGMENTS;
  localparam int NC    = NUM_C_SEGMENTS;
  localparam int CW    = COUNT_WIDTH;
  localparam int CELLS = NA * NB * NC;
  localparam int MW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int AW    = (NA > 1) ? $clog2(NA) : 1;
  localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
  localparam int OW    = ccm_pkg::OutCountWidth;
  localparam int RW    = ccm_pkg::RatioWidth;

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EVA  = 4'd2;
  localparam logic [3:0] S_EVB  = 4'd3;
  localparam logic [3:0] S_EVC  = 4'd4;
  localparam logic [3:0] S_EVWR = 4'd5;
  localparam logic [3:0] S_QRD  = 4'd6;
  localparam logic [3:0] S_QDIV = 4'd7;
  localparam logic [3:0] S_QOUT = 4'd8;

  logic [3:0] state_q, state_d;

  // thresholds
  logic [15:0] thr_a_q, thr_b_q, thr_c_q;

  // event masks and counters
  logic [NA-1:0] mask_a_q;
  logic [NB-1:0] mask_b_q;
  logic [NC-1:0] mask_c_q;
  logic [CW-1:0] any_a_q;
  logic [CW-1:0] seg_cnt_q [NA];

  logic [AW-1:0]  a_q, a_d;
  logic [BW-1:0]  b_q, b_d;
  logic [CIW-1:0] c_q, c_d;
  logic [MW-1:0]  clr_addr_q;

  // triple store
  logic [CW-1:0] tri_mem [CELLS];
  logic [CW-1:0] rd_q;
  logic [MW-1:0] mem_addr;
  logic          mem_we;
  logic [CW-1:0] mem_wdata;

  // query staging and output register
  logic [CW-1:0] res_num_q, res_den_q;
  logic          res_err_q;
  logic [OW-1:0] out_num_q, out_den_q;
  logic [RW-1:0] out_ratio_q;
  logic          out_err_q, out_valid_q;

  logic          div_start, div_done;
  logic [RW-1:0] div_ratio;

  // field unpacking
  logic [1:0]  in_plane;
  logic [6:0]  in_seg;
  logic [15:0] in_energy;
  logic [5:0]  in_qa, in_qb, in_qc;
  logic        in_den_any;

  assign in_plane   = s_axis_tdata[1:0];
  assign in_seg     = s_axis_tdata[8:2];
  assign in_energy  = s_axis_tdata[24:9];
  assign in_qa      = s_axis_tdata[30:25];
  assign in_qb      = s_axis_tdata[36:31];
  assign in_qc      = s_axis_tdata[42:37];
  assign in_den_any = s_axis_tdata[43];

  logic accept, a_last, b_last, c_last, clr_last, q_err, eoe_go, eoe_done, seg_inc;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign a_last   = (a_q == AW'(NA - 1));
  assign b_last   = (b_q == BW'(NB - 1));
  assign c_last   = (c_q == CIW'(NC - 1));
  assign clr_last = (clr_addr_q == MW'(CELLS - 1));
  assign q_err    = ({1'b0, in_qa} >= 7'(NA)) || ({1'b0, in_qb} >= 7'(NB))
                 || ({1'b0, in_qc} >= 7'(NC));

  assign s_axis_tready = (state_q == S_IDLE);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == '1) ? v : v + CW'(1);
  endfunction

  // sequencer
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    mem_we    = 1'b0;
    div_start = 1'b0;
    eoe_go    = 1'b0;
    eoe_done  = 1'b0;
    seg_inc   = 1'b0;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            ccm_pkg::OP_EOE: begin
              if (mask_a_q != '0) begin
                eoe_go  = 1'b1;
                a_d     = '0;
                state_d = S_EVA;
              end else begin
                eoe_done = 1'b1;
              end
            end
            ccm_pkg::OP_QUERY: begin
              state_d = q_err ? S_QOUT : S_QRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_EVA: begin
        if (mask_a_q[a_q]) begin
          seg_inc = 1'b1;
          b_d     = '0;
          state_d = S_EVB;
        end else if (a_last) begin
          eoe_done = 1'b1;
          state_d  = S_IDLE;
        end else begin
          a_d = a_q + AW'(1);
        end
      end
      S_EVB, S_EVC, S_EVWR: begin
        logic adv_b;
        adv_b = 1'b0;
        if (state_q == S_EVB) begin
          if (mask_b_q[b_q]) begin
            c_d     = '0;
            state_d = S_EVC;
          end else begin
            adv_b = 1'b1;
          end
        end else if (state_q == S_EVC && mask_c_q[c_q]) begin
          state_d = S_EVWR;
        end else begin
          mem_we = (state_q == S_EVWR);
          if (c_last) begin
            adv_b = 1'b1;
          end else begin
            c_d     = c_q + CIW'(1);
            state_d = S_EVC;
          end
        end
        if (adv_b) begin
          if (!b_last) begin
            b_d     = b_q + BW'(1);
            state_d = S_EVB;
          end else if (a_last) begin
            eoe_done = 1'b1;
            state_d  = S_IDLE;
          end else begin
            a_d     = a_q + AW'(1);
            state_d = S_EVA;
          end
        end
      end
      S_QRD: begin
        div_start = 1'b1;
        state_d   = S_QDIV;
      end
      S_QDIV: begin
        if (div_done) begin
          state_d = S_QOUT;
        end
      end
      S_QOUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // one port of the triple store, shared by clear sweep, event walk and query
  always_comb begin
    if (state_q == S_CLR) begin
      mem_addr = clr_addr_q;
    end else if (state_q == S_IDLE) begin
      mem_addr = MW'(int'(in_qa) * (NB * NC) + int'(in_qb) * NC + int'(in_qc));
    end else begin
      mem_addr = MW'(int'(a_q) * (NB * NC) + int'(b_q) * NC + int'(c_q));
    end
  end
  assign mem_wdata = (state_q == S_CLR) ? '0 : sat_inc(rd_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tri_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= tri_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_addr_q  <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      thr_a_q     <= ccm_pkg::THR_A_RST;
      thr_b_q     <= ccm_pkg::THR_B_RST;
      thr_c_q     <= ccm_pkg::THR_C_RST;
      mask_a_q    <= '0;
      mask_b_q    <= '0;
      mask_c_q    <= '0;
      any_a_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        seg_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      c_q     <= c_d;
      if (state_q == S_CLR) begin
        clr_addr_q <= clr_addr_q + MW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ccm_pkg::REG_THR_A: thr_a_q <= cfg_data_i;
          ccm_pkg::REG_THR_B: thr_b_q <= cfg_data_i;
          ccm_pkg::REG_THR_C: thr_c_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      // hit capture, negative segments dropped
      if (accept && s_axis_tuser == ccm_pkg::OP_HIT && !in_seg[6]) begin
        case (in_plane)
          ccm_pkg::PLANE_A: begin
            if (in_energy > thr_a_q && {1'b0, in_seg[5:0]} < 7'(NA)) begin
              mask_a_q[in_seg[AW-1:0]] <= 1'b1;
            end
          end
          ccm_pkg::PLANE_B: begin
            if (in_energy > thr_b_q && {1'b0, in_seg[5:0]} < 7'(NB)) begin
              mask_b_q[in_seg[BW-1:0]] <= 1'b1;
            end
          end
          ccm_pkg::PLANE_C: begin
            if (in_energy > thr_c_q && {1'b0, in_seg[5:0]} < 7'(NC)) begin
              mask_c_q[in_seg[CIW-1:0]] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (eoe_go) begin
        any_a_q <= sat_inc(any_a_q);
      end
      if (seg_inc) begin
        seg_cnt_q[a_q] <= sat_inc(seg_cnt_q[a_q]);
      end
      if (eoe_done) begin
        mask_a_q <= '0;
        mask_b_q <= '0;
        mask_c_q <= '0;
      end
      // output register
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_QOUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // query staging
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == ccm_pkg::OP_QUERY) begin
      res_err_q <= q_err;
      res_num_q <= '0;
      if (q_err) begin
        res_den_q <= '0;
      end else if (in_den_any) begin
        res_den_q <= any_a_q;
      end else begin
        res_den_q <= seg_cnt_q[in_qa[AW-1:0]];
      end
    end
    if (state_q == S_QRD) begin
      res_num_q <= rd_q;
    end
    if (state_q == S_QOUT && (!out_valid_q || m_axis_tready)) begin
      out_num_q   <= OW'(res_num_q);
      out_den_q   <= OW'(res_den_q);
      out_ratio_q <= res_err_q ? '0 : div_ratio;
      out_err_q   <= res_err_q;
    end
  end

  ccm_ratio #(
    .W(CW)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rd_q),
    .den_i   (res_den_q),
    .done_o  (div_done),
    .ratio_o (div_ratio)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_err_q, out_ratio_q, out_den_q, out_num_q};

  // a hit never starts a multi-cycle walk
  a_hit_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == ccm_pkg::OP_HIT) |=> (state_q == S_IDLE))
    else $error("hit item left the sequencer busy");

  // index errors carry no counts
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_err_q) |-> (out_num_q == '0 && out_den_q == '0 && out_ratio_q == '0))
    else $error("index error result carries counts");

  // ratio never exceeds full scale
  a_ratio_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_ratio_q <= ccm_pkg::RATIO_SCALE))
    else $error("ratio above full scale");

  // store writes only in sweep or walk
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_EVWR))
    else $error("triple store written outside sweep or walk");

endmodule

`default_nettype wire
